// File: rtl/core/imdct12_pkg.sv
package imdct12_pkg;

   localparam int unsigned WordWidth     = 32;
   localparam int unsigned ProductWidth  = 2 * WordWidth;
   localparam int unsigned SampleCount   = 6;
   localparam int unsigned CsrIndexWidth = 8;

   typedef logic [WordWidth-1:0] word_type;

   // configuration register map
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_COS30_HALF = 8'd0,
      CSR_MID_TERM   = 8'd1,
      CSR_SUM_TERM   = 8'd2,
      CSR_DIFF_TERM  = 8'd3
   } csr_index_type;

   localparam word_type CoefCos30HalfReset = 32'd1859775393;
   localparam word_type CoefMidTermReset   = 32'd1518500250;
   localparam word_type CoefSumTermReset   = 32'd1111619334;
   localparam word_type CoefDiffTermReset  = 32'd2074309917;

   typedef struct packed {
      word_type cos30_half;
      word_type mid_term;
      word_type sum_term;
      word_type diff_term;
   } coef_type;

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w2;
      word_type w3;
      word_type w4;
      word_type w5;
   } sample_type;

   // running sums after the first stage
   typedef struct packed {
      word_type a0;
      word_type a1;
      word_type a2;
      word_type a3;
      word_type a4;
      word_type a5;
   } prefix_type;

   // multiplier operands plus the terms that bypass the multipliers
   typedef struct packed {
      word_type d;
      word_type base;
      word_type op_a2;
      word_type op_a3;
      word_type op_mid;
      word_type mix;
   } operand_type;

   // first rank of products, mix still waits for the scaled third sum
   typedef struct packed {
      word_type d;
      word_type base;
      word_type mix;
      word_type p_a2;
      word_type p_a3;
      word_type p_mid;
   } partial_type;

   typedef struct packed {
      word_type d;
      word_type base;
      word_type p_a2;
      word_type p_mid;
      word_type p_sum;
      word_type p_diff;
   } product_type;

   typedef struct packed {
      word_type y_pair_0_5;
      word_type y_pair_1_4;
      word_type y_pair_2_3;
      word_type y_pair_6_11;
      word_type y_pair_7_10;
      word_type y_pair_8_9;
   } result_type;

   // high word of the signed 64-bit product
   function automatic word_type qmul(input word_type value, input word_type coef);
      logic signed [ProductWidth-1:0] prod;
      prod = $signed(value) * $signed(coef);
      return prod[ProductWidth-1:WordWidth];
   endfunction

endpackage

// File: rtl/core/imdct12_csr.sv
module imdct12_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [imdct12_pkg::CsrIndexWidth-1:0] csr_index,
   input  imdct12_pkg::word_type                 csr_wdata,
   output imdct12_pkg::coef_type                 coef
);
   import imdct12_pkg::*;

   coef_type coef_ff;
   coef_type coef_in;

   assign csr_ready = 1'b1;
   assign coef      = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COS30_HALF: coef_in.cos30_half = csr_wdata;
            CSR_MID_TERM:   coef_in.mid_term   = csr_wdata;
            CSR_SUM_TERM:   coef_in.sum_term   = csr_wdata;
            CSR_DIFF_TERM:  coef_in.diff_term  = csr_wdata;
            default:        coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.cos30_half <= CoefCos30HalfReset;
         coef_ff.mid_term   <= CoefMidTermReset;
         coef_ff.sum_term   <= CoefSumTermReset;
         coef_ff.diff_term  <= CoefDiffTermReset;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

// File: rtl/core/imdct12_prefix.sv
module imdct12_prefix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  imdct12_pkg::sample_type in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output imdct12_pkg::prefix_type out_data
);
   import imdct12_pkg::*;

   logic       valid_ff;
   prefix_type data_ff;
   prefix_type data_in;
   word_type   a3_raw;
   word_type   a1_raw;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      a1_raw     = in_data.w1 + in_data.w0;
      a3_raw     = in_data.w3 + in_data.w2;
      data_in.a0 = in_data.w0;
      data_in.a1 = a1_raw;
      data_in.a2 = in_data.w2 + in_data.w1;
      data_in.a3 = a3_raw + a1_raw;
      data_in.a4 = in_data.w4 + in_data.w3;
      data_in.a5 = (in_data.w5 + in_data.w4) + a3_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/core/imdct12_operand.sv
module imdct12_operand (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  imdct12_pkg::prefix_type  in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output imdct12_pkg::operand_type out_data
);
   import imdct12_pkg::*;

   logic        valid_ff;
   operand_type data_ff;
   operand_type data_in;
   word_type    a5_mix;
   word_type    mid_diff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      a5_mix          = in_data.a5 + {in_data.a1[WordWidth-2:0], 1'b0};
      mid_diff        = in_data.a1 - in_data.a5;
      data_in.d       = in_data.a0 - in_data.a4;
      // halving keeps the sign
      data_in.base    = in_data.a0 + word_type'($signed(in_data.a4) >>> 1);
      data_in.op_a2   = {in_data.a2[WordWidth-2:0], 1'b0};
      data_in.op_a3   = {in_data.a3[WordWidth-3:0], 2'b00};
      data_in.op_mid  = {mid_diff[WordWidth-2:0], 1'b0};
      data_in.mix     = a5_mix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/core/imdct12_mult.sv
module imdct12_mult (
   input  logic                     clock,
   input  logic                     reset,
   input  imdct12_pkg::coef_type    coef,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  imdct12_pkg::operand_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output imdct12_pkg::product_type out_data
);
   import imdct12_pkg::*;

   logic        part_valid_ff;
   partial_type part_ff;
   partial_type part_in;
   logic        part_ready;
   logic        valid_ff;
   product_type data_ff;
   product_type data_in;
   word_type    sum_op;
   word_type    diff_op;

   assign in_ready   = !part_valid_ff || part_ready;
   assign part_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;

   // first rank: three 32x32 multipliers straight from the operands
   always_comb begin
      part_in.d     = in_data.d;
      part_in.base  = in_data.base;
      part_in.mix   = in_data.mix;
      part_in.p_a2  = qmul(in_data.op_a2,  coef.cos30_half);
      part_in.p_a3  = qmul(in_data.op_a3,  coef.cos30_half);
      part_in.p_mid = qmul(in_data.op_mid, coef.mid_term);
   end

   // second rank: the scaled third sum feeds the sum and difference products
   always_comb begin
      sum_op         = part_ff.mix + part_ff.p_a3;
      diff_op        = part_ff.mix - part_ff.p_a3;
      data_in.d      = part_ff.d;
      data_in.base   = part_ff.base;
      data_in.p_a2   = part_ff.p_a2;
      data_in.p_mid  = part_ff.p_mid;
      data_in.p_sum  = qmul(sum_op, coef.sum_term);
      data_in.p_diff = qmul({diff_op[WordWidth-2:0], 1'b0}, coef.diff_term);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_valid_ff <= 1'b0;
      end else if (in_ready) begin
         part_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (part_ready) begin
         valid_ff <= part_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (part_valid_ff && part_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/core/imdct12_bfly.sv
module imdct12_bfly (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  imdct12_pkg::product_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output imdct12_pkg::result_type  out_data
);
   import imdct12_pkg::*;

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;
   word_type   s;
   word_type   t;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      s = in_data.base + in_data.p_a2;
      t = in_data.base - in_data.p_a2;
      data_in.y_pair_7_10 = in_data.d + in_data.p_mid;
      data_in.y_pair_1_4  = in_data.d - in_data.p_mid;
      data_in.y_pair_8_9  = s + in_data.p_sum;
      data_in.y_pair_2_3  = s - in_data.p_sum;
      data_in.y_pair_0_5  = t - in_data.p_diff;
      data_in.y_pair_6_11 = t + in_data.p_diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: rtl/core/imdct12_short_block_core.sv
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  six block words, 32 bits each
// rsp       out        rsp_tvalid/rsp_tready  six output pair values, 32 bits each
// csr       in         csr_valid/csr_ready    register index and 32-bit write data
//
// five register stages: prefix sums, multiplier operands, first products,
// sum and difference products, butterflies
// one item per cycle sustained while rsp is not stalled
// synchronous reset empties the pipe and loads the default coefficients
// each stage holds its item while the next one is full and stalled,
// so bubbles close up and a stall on rsp loses or repeats nothing
// csr writes are always taken and land in the next cycle
module imdct12_short_block_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // req: sample_0 [31:0], sample_3, sample_6, sample_9, sample_12, sample_15 [191:160]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [191:0]                          req_tdata,
   // rsp: y_pair_0_5 [31:0], y_pair_1_4, y_pair_2_3, y_pair_6_11, y_pair_7_10,
   //      y_pair_8_9 [191:160]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [191:0]                          rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [imdct12_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                           csr_wdata
);
   import imdct12_pkg::*;

   coef_type    coef;
   sample_type  samples;
   prefix_type  prefix;
   operand_type operand;
   product_type product;
   result_type  result;

   // handshake between stages
   logic prefix_valid;
   logic prefix_ready;
   logic operand_valid;
   logic operand_ready;
   logic product_valid;
   logic product_ready;

   // unpack block words, lowest field first
   assign samples.w0 = req_tdata[31:0];
   assign samples.w1 = req_tdata[63:32];
   assign samples.w2 = req_tdata[95:64];
   assign samples.w3 = req_tdata[127:96];
   assign samples.w4 = req_tdata[159:128];
   assign samples.w5 = req_tdata[191:160];

   imdct12_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   // stage 1: running sums of the block words
   imdct12_prefix u_prefix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (samples),
      .out_valid (prefix_valid),
      .out_ready (prefix_ready),
      .out_data  (prefix)
   );

   // stage 2: scaled multiplier operands and bypass terms
   imdct12_operand u_operand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prefix_valid),
      .in_ready  (prefix_ready),
      .in_data   (prefix),
      .out_valid (operand_valid),
      .out_ready (operand_ready),
      .out_data  (operand)
   );

   // stages 3 and 4: q32 products against the coefficient registers,
   // the sum and difference products need the scaled third sum first
   imdct12_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (operand_valid),
      .in_ready  (operand_ready),
      .in_data   (operand),
      .out_valid (product_valid),
      .out_ready (product_ready),
      .out_data  (product)
   );

   // stage 5: butterflies into the output register
   imdct12_bfly u_bfly (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (product_valid),
      .in_ready  (product_ready),
      .in_data   (product),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   // pack result pairs, lowest field first
   assign rsp_tdata = {result.y_pair_8_9, result.y_pair_7_10, result.y_pair_6_11,
                       result.y_pair_2_3, result.y_pair_1_4, result.y_pair_0_5};

endmodule
